// File: hw/rtl/skf_pkg.sv
// Package of shared types, constants and the scancode table for the key FIFO.
`default_nettype none

package skf_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CHAR_W = 7;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;
    localparam logic [1:0] STATUS_EMPTY   = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] scan_byte;
    } skf_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] key_char;
        logic [1:0]        status;
        logic              buffer_nonempty;
    } skf_out_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic load_direct;
        logic load_read;
    } skf_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic mapped;
    } skf_stat_t;

    function automatic logic [CHAR_W-1:0] keymap_lookup(input logic [7:0] code);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        unique case (code)
            8'd2:    ch = 7'h31;
            8'd3:    ch = 7'h32;
            8'd4:    ch = 7'h33;
            8'd5:    ch = 7'h34;
            8'd6:    ch = 7'h35;
            8'd7:    ch = 7'h36;
            8'd8:    ch = 7'h37;
            8'd9:    ch = 7'h38;
            8'd10:   ch = 7'h39;
            8'd11:   ch = 7'h30;
            8'd12:   ch = 7'h2d;
            8'd13:   ch = 7'h3d;
            8'd14:   ch = 7'h08;
            8'd15:   ch = 7'h09;
            8'd16:   ch = 7'h71;
            8'd17:   ch = 7'h77;
            8'd18:   ch = 7'h65;
            8'd19:   ch = 7'h72;
            8'd20:   ch = 7'h74;
            8'd21:   ch = 7'h79;
            8'd22:   ch = 7'h75;
            8'd23:   ch = 7'h69;
            8'd24:   ch = 7'h6f;
            8'd25:   ch = 7'h70;
            8'd26:   ch = 7'h5b;
            8'd27:   ch = 7'h5d;
            8'd28:   ch = 7'h0a;
            8'd30:   ch = 7'h61;
            8'd31:   ch = 7'h73;
            8'd32:   ch = 7'h64;
            8'd33:   ch = 7'h66;
            8'd34:   ch = 7'h67;
            8'd35:   ch = 7'h68;
            8'd36:   ch = 7'h6a;
            8'd37:   ch = 7'h6b;
            8'd38:   ch = 7'h6c;
            8'd39:   ch = 7'h3b;
            8'd40:   ch = 7'h27;
            8'd41:   ch = 7'h60;
            8'd43:   ch = 7'h5c;
            8'd44:   ch = 7'h7a;
            8'd45:   ch = 7'h78;
            8'd46:   ch = 7'h63;
            8'd47:   ch = 7'h76;
            8'd48:   ch = 7'h62;
            8'd49:   ch = 7'h6e;
            8'd50:   ch = 7'h6d;
            8'd51:   ch = 7'h2c;
            8'd52:   ch = 7'h2e;
            8'd53:   ch = 7'h2f;
            8'd55:   ch = 7'h2a;
            8'd57:   ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scancode_to_ascii_key_fifo_top.sv
// Top level of the scancode to ASCII translator with its key FIFO.
// Scancode transactions and reads of an empty buffer load the result register directly; a
// read that pops a key passes the read state, as the key store is a RAM with registered read
// data. The store holds DEPTH-1 keys, and a result waiting at the output register holds off
// the next transaction only until it is taken. The store needs no clearing pass after reset.
`default_nettype none

module scancode_to_ascii_key_fifo_top
    import skf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire skf_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output skf_out_t     out_data
);

    skf_cmd_t  cmd;
    skf_stat_t stat;

    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (in_data.req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    skf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// File: hw/rtl/skf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module skf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/skf_ctrl.sv
// Controller state machine that sequences transactions through the datapath.
`default_nettype none

module skf_ctrl
    import skf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      req_type,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire skf_stat_t stat,
    output skf_cmd_t       cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.push        = accept && (req_type == REQ_SCAN) && stat.mapped && !stat.full;
        cmd.pop         = accept && (req_type == REQ_READ) && !stat.empty;
        cmd.load_direct = accept && !((req_type == REQ_READ) && !stat.empty);
        cmd.load_read   = (state_reg == S_READ) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.pop)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd.load_read)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.load_direct || cmd.load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/skf_datapath.sv
// Datapath with the scancode table, ring buffer indices, key store and result register.
`default_nettype none

module skf_datapath
    import skf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire skf_in_t  in_data,
    input  wire skf_cmd_t cmd,
    output skf_stat_t     stat,
    output skf_out_t      out_data
);

    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  wr_idx_next;
    logic [IDX_W-1:0]  wr_idx_adv;
    logic [IDX_W-1:0]  rd_idx_adv;
    logic [CHAR_W-1:0] mapped_char;
    logic [CHAR_W-1:0] ram_rd_data;
    skf_out_t          out_data_reg;
    skf_out_t          out_data_next;
    logic [1:0]        direct_status;

    assign mapped_char = keymap_lookup(in_data.scan_byte);
    assign wr_idx_adv  = (wr_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_adv  = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;

    always_comb
    begin
        stat.empty  = (rd_idx_reg == wr_idx_reg);
        stat.full   = (wr_idx_adv == rd_idx_reg);
        stat.mapped = (mapped_char != '0);
    end

    skf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wr_idx_reg),
        .wr_data (mapped_char),
        .rd_en   (cmd.pop),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        rd_idx_next = cmd.pop ? rd_idx_adv : rd_idx_reg;
        wr_idx_next = cmd.push ? wr_idx_adv : wr_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    always_comb
    begin
        priority if (in_data.req_type == REQ_READ)
        begin
            direct_status = STATUS_EMPTY;
        end
        else if (!stat.mapped)
        begin
            direct_status = STATUS_IGNORED;
        end
        else if (stat.full)
        begin
            direct_status = STATUS_DROPPED;
        end
        else
        begin
            direct_status = STATUS_OK;
        end

        out_data_next = out_data_reg;
        if (cmd.load_direct)
        begin
            out_data_next.key_char        = '0;
            out_data_next.status          = direct_status;
            out_data_next.buffer_nonempty = cmd.push || !stat.empty;
        end
        else if (cmd.load_read)
        begin
            out_data_next.key_char        = ram_rd_data;
            out_data_next.status          = STATUS_OK;
            out_data_next.buffer_nonempty = !stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/skf_checker.sv
// Port-level checker for the key FIFO top level and its bind statement.
`default_nettype none

module skf_checker
    import skf_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire skf_in_t  in_data,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire skf_out_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("Input transaction changed or vanished while stalled.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Result changed or vanished while stalled.");

    a_char_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != STATUS_OK) |-> (out_data.key_char == '0))
        else $error("Nonzero character with a non-ok status.");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_EMPTY) |-> !out_data.buffer_nonempty)
        else $error("Empty read reported a non-empty buffer.");

    a_dropped_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_DROPPED) |-> out_data.buffer_nonempty)
        else $error("Dropped key reported an empty buffer.");

endmodule

bind scancode_to_ascii_key_fifo_top skf_checker u_checker (.*);

`default_nettype wire
